@@ hw/rtl/video_memory_access_port_unit_assert.svh @@
`ifndef VIDEO_MEMORY_ACCESS_PORT_UNIT_ASSERT_SVH
`define VIDEO_MEMORY_ACCESS_PORT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define VMAP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("video memory port assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define VMAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("video memory port assertion failed");

`endif

@@ hw/rtl/vmap_pkg.sv @@
package vmap_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [OPCODE_W-1:0] OP_ADDR_LO = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADDR_HI = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DATA_LO = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DATA_HI = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ_LO = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ_HI = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SELECT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_MAPPING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_ON_HIGH = 2'd2;

  localparam logic [1:0] MAP_NONE  = 2'd0;
  localparam logic [1:0] MAP_ROT8  = 2'd1;
  localparam logic [1:0] MAP_ROT9  = 2'd2;
  localparam logic [1:0] MAP_ROT10 = 2'd3;

  typedef struct packed {
    logic accept;  // a request is taken this cycle
    logic go;      // memory access, address advance and result capture
    logic load;    // a due refill loads the registered read data into the prefetch word
  } vmap_cmd_t;

  typedef struct packed {
    logic out_busy;  // result register full and not being taken
  } vmap_status_t;

  function automatic logic [WORD_W-1:0] step_size(input logic [1:0] sel);
    logic [WORD_W-1:0] s;
    case (sel)
      2'd0:    s = 16'd1;
      2'd1:    s = 16'd32;
      default: s = 16'd128;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/vmap_if.sv @@
interface vmap_in_if
  import vmap_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   data_byte;
  logic                active_display;

  modport source (output valid, opcode, data_byte, active_display, input ready);
  modport sink   (input valid, opcode, data_byte, active_display, output ready);
endinterface

interface vmap_out_if
  import vmap_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

interface vmap_cfg_if
  import vmap_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/vmap_ctrl.sv @@
module vmap_ctrl
  import vmap_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  vmap_status_t status_i,
  output vmap_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACCESS = 2'd1;
  localparam logic [1:0] ST_LOAD   = 2'd2;

  logic [1:0] state_q, state_d;

  // The next request may enter while the prefetch word is being loaded.
  assign in_ready_o   = (state_q == ST_IDLE) || (state_q == ST_LOAD);
  assign cmd_o.accept = in_valid_i && in_ready_o;
  assign cmd_o.go     = (state_q == ST_ACCESS) && !status_i.out_busy;
  assign cmd_o.load   = (state_q == ST_LOAD);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept) state_d = ST_ACCESS;
      end
      ST_ACCESS: begin
        if (cmd_o.go) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = cmd_o.accept ? ST_ACCESS : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/vmap_datapath.sv @@
module vmap_datapath
  import vmap_pkg::*;
#(
  parameter int unsigned MEM_ADDR_BITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vmap_cmd_t             cmd_i,
  output vmap_status_t          status_o,
  input  logic [OPCODE_W-1:0]   opcode_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  active_display_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BYTE_W-1:0]     read_data_o
);

  localparam int unsigned MEM_WORDS = 1 << MEM_ADDR_BITS;

  logic [1:0]          step_select_q;
  logic [1:0]          address_mapping_q;
  logic                advance_on_high_q;

  logic [OPCODE_W-1:0] op_q;
  logic [BYTE_W-1:0]   data_q;
  logic                blocked_q;
  logic                blocked_load_q;

  logic [WORD_W-1:0]   addr_q;
  logic [WORD_W-1:0]   prefetch_q;
  logic [WORD_W-1:0]   rdata_q;
  logic [WORD_W-1:0]   mapped;
  logic [MEM_ADDR_BITS-1:0] mem_idx;

  logic                out_valid_q;
  logic [BYTE_W-1:0]   out_data_q;

  logic                advance_now;
  logic                write_lo;
  logic                write_hi;
  logic [BYTE_W-1:0]   result;

  logic [WORD_W-1:0]   mem_q [MEM_WORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_select_q     <= 2'd0;
      address_mapping_q <= MAP_NONE;
      advance_on_high_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STEP_SELECT:     step_select_q     <= cfg_data_i[1:0];
        CFG_ADDRESS_MAPPING: address_mapping_q <= cfg_data_i[1:0];
        CFG_ADVANCE_ON_HIGH: advance_on_high_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The top three bits of the low 8, 9 or 10 address bits rotate to the bottom.
  always_comb begin
    case (address_mapping_q)
      MAP_ROT8:  mapped = {addr_q[15:8],  addr_q[4:0], addr_q[7:5]};
      MAP_ROT9:  mapped = {addr_q[15:9],  addr_q[5:0], addr_q[8:6]};
      MAP_ROT10: mapped = {addr_q[15:10], addr_q[6:0], addr_q[9:7]};
      default:   mapped = addr_q;
    endcase
  end

  assign mem_idx = mapped[MEM_ADDR_BITS-1:0];

  assign write_lo = (op_q == OP_DATA_LO) && !blocked_q;
  assign write_hi = (op_q == OP_DATA_HI) && !blocked_q;

  always_comb begin
    case (op_q)
      OP_DATA_LO, OP_READ_LO: advance_now = !advance_on_high_q;
      OP_DATA_HI, OP_READ_HI: advance_now = advance_on_high_q;
      default:                advance_now = 1'b0;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_READ_LO: result = prefetch_q[7:0];
      OP_READ_HI: result = prefetch_q[15:8];
      default:    result = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= opcode_i;
      data_q    <= data_byte_i;
      blocked_q <= active_display_i;
    end
    if (cmd_i.go) begin
      blocked_load_q <= blocked_q;
      out_data_q     <= result;
    end
  end

  // Byte-enable writes; the read port samples the pre-advance address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.go && write_lo) mem_q[mem_idx][7:0]  <= data_q;
    if (cmd_i.go && write_hi) mem_q[mem_idx][15:8] <= data_q;
    rdata_q <= mem_q[mem_idx];
  end

  logic refill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      prefetch_q  <= '0;
      refill_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && opcode_i == OP_ADDR_LO) addr_q[7:0]  <= data_byte_i;
      if (cmd_i.accept && opcode_i == OP_ADDR_HI) addr_q[15:8] <= data_byte_i;
      if (cmd_i.go && advance_now) addr_q <= addr_q + step_size(step_select_q);
      if (cmd_i.go) begin
        refill_q <= (op_q == OP_ADDR_LO) || (op_q == OP_ADDR_HI)
                    || (advance_now && ((op_q == OP_READ_LO) || (op_q == OP_READ_HI)));
      end
      if (cmd_i.load && refill_q) prefetch_q <= blocked_load_q ? '0 : rdata_q;
      if (cmd_i.go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign read_data_o       = out_data_q;

endmodule

@@ hw/rtl/video_memory_access_port_unit.sv @@
// Byte-wide CPU port onto a word-organized video memory.
// Requests enter on in_i (opcode, data_byte, active_display); every request
// yields exactly one result byte on out_o, which is zero except for reads.
// Configuration registers (step select, address mapping, advance on high)
// are written through cfg_i, which is always ready; the user must write
// them only while no request is open; the block does not enforce this.
// A request passes through the memory access stage, where the write, the
// address advance and the result capture happen, and then the load stage,
// which loads the prefetch word from the registered memory read port. The
// next request may be taken during the load stage, before the last one is
// through. out_o.valid is registered and rises once the access stage has
// captured the result. If the receiver stalls, the finished result waits
// in the output register and the following request holds in the access
// stage until the register frees up; in_i.ready stays low meanwhile.
// Reset clears the address, the prefetch word and the configuration; the
// memory itself holds unspecified data until written.
module video_memory_access_port_unit
  import vmap_pkg::*;
#(
  parameter int unsigned MEM_ADDR_BITS = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vmap_in_if.sink   in_i,
  vmap_out_if.source out_o,
  vmap_cfg_if.sink  cfg_i
);

  vmap_cmd_t    cmd;
  vmap_status_t status;

  assign cfg_i.ready = 1'b1;

  vmap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vmap_datapath #(
    .MEM_ADDR_BITS (MEM_ADDR_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .opcode_i         (in_i.opcode),
    .data_byte_i      (in_i.data_byte),
    .active_display_i (in_i.active_display),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .read_data_o      (out_o.read_data)
  );

`include "video_memory_access_port_unit_assert.svh"

  `VMAP_ASSERT_NEXT(a_accept_closes_input, cmd.accept, !in_i.ready)
  `VMAP_ASSERT_NEXT(a_go_gives_result, cmd.go, out_o.valid)
  `VMAP_ASSERT_NEXT(a_go_then_load, cmd.go, cmd.load && in_i.ready)
  `VMAP_ASSERT_IMPL(a_no_go_when_busy, cmd.go, !(out_o.valid && !out_o.ready))

endmodule

@@ test/vmap_port_checker.sv @@
module vmap_port_checker
  import vmap_pkg::*;
#(
  parameter int unsigned MEM_ADDR_BITS = 15
) (
  input  logic clk_i,
  input  logic rst_ni,
  vmap_in_if   in_mon,
  vmap_out_if  out_mon,
  vmap_cfg_if  cfg_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  localparam logic [WORD_W-1:0] STRIDE [4] = '{16'd1, 16'd32, 16'd128, 16'd128};

  logic [WORD_W-1:0] vram [0:(1 << MEM_ADDR_BITS)-1];
  logic [WORD_W-1:0] word_addr;
  logic [WORD_W-1:0] prefetch;
  logic [1:0]        step_sel;
  logic [1:0]        addr_map;
  logic              adv_high;
  logic [BYTE_W-1:0] expected_bytes [$];
  logic [BYTE_W-1:0] want;

  function automatic logic [MEM_ADDR_BITS-1:0] vram_index(input logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] m;
    case (addr_map)
      MAP_ROT8:  m = {a[15:8], a[4:0], a[7:5]};
      MAP_ROT9:  m = {a[15:9], a[5:0], a[8:6]};
      MAP_ROT10: m = {a[15:10], a[6:0], a[9:7]};
      default:   m = a;
    endcase
    return m[MEM_ADDR_BITS-1:0];
  endfunction

  // While the display owns the memory, a refill loads zero.
  function automatic logic [WORD_W-1:0] fetch_word(input logic blocked);
    return blocked ? '0 : vram[vram_index(word_addr)];
  endfunction

  task automatic apply_request(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] din,
                               input logic blocked);
    logic [BYTE_W-1:0]        rd;
    logic [MEM_ADDR_BITS-1:0] idx;
    rd  = '0;
    idx = vram_index(word_addr);
    case (op)
      OP_ADDR_LO: begin
        word_addr[7:0] = din;
        prefetch = fetch_word(blocked);
      end
      OP_ADDR_HI: begin
        word_addr[15:8] = din;
        prefetch = fetch_word(blocked);
      end
      OP_DATA_LO: begin
        if (!blocked) vram[idx][7:0] = din;
        if (!adv_high) word_addr = word_addr + STRIDE[step_sel];
      end
      OP_DATA_HI: begin
        if (!blocked) vram[idx][15:8] = din;
        if (adv_high) word_addr = word_addr + STRIDE[step_sel];
      end
      OP_READ_LO: begin
        rd = prefetch[7:0];
        if (!adv_high) begin
          prefetch  = fetch_word(blocked);
          word_addr = word_addr + STRIDE[step_sel];
        end
      end
      OP_READ_HI: begin
        rd = prefetch[15:8];
        if (adv_high) begin
          prefetch  = fetch_word(blocked);
          word_addr = word_addr + STRIDE[step_sel];
        end
      end
      default: ;
    endcase
    expected_bytes.push_back(rd);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_addr = '0;
      prefetch  = '0;
      step_sel  = '0;
      addr_map  = MAP_NONE;
      adv_high  = 1'b0;
      expected_bytes.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // Results leave before this edge's request enters, so the oldest
      // expectation always belongs to the result on the bus.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("read_data: no request outstanding, expected none, actual 0x%02h",
                 out_mon.read_data);
          fail_count_o++;
        end else begin
          want = expected_bytes.pop_front();
          checked_o++;
          if (out_mon.read_data !== want) begin
            $error("read_data mismatch: expected 0x%02h, actual 0x%02h",
                   want, out_mon.read_data);
            fail_count_o++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_STEP_SELECT:     step_sel = cfg_mon.data[1:0];
          CFG_ADDRESS_MAPPING: addr_map = cfg_mon.data[1:0];
          CFG_ADVANCE_ON_HIGH: adv_high = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        apply_request(in_mon.opcode, in_mon.data_byte, in_mon.active_display);
      pending_o = expected_bytes.size();
    end
  end

endmodule

@@ test/video_memory_access_port_unit_tb.sv @@
module video_memory_access_port_unit_tb;
  import vmap_pkg::*;

  localparam int unsigned MEM_ADDR_BITS   = 15;
  localparam int unsigned PHASE_COUNT     = 8;
  localparam int unsigned PHASE_ITEMS     = 185;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] STRIDE [4] = '{16'd1, 16'd32, 16'd128, 16'd128};

  logic clk_i;
  logic rst_ni;

  vmap_in_if  in_if ();
  vmap_out_if out_if ();
  vmap_cfg_if cfg_if ();

  int fail_count;
  int pending;
  int checked;

  video_memory_access_port_unit #(
    .MEM_ADDR_BITS(MEM_ADDR_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  vmap_port_checker #(
    .MEM_ADDR_BITS(MEM_ADDR_BITS)
  ) u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_mon     (cfg_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Shadow of the address and of which bytes were stored, so that no
  // request ever refills the prefetch word from a word never written.
  logic [WORD_W-1:0] sh_addr;
  logic [1:0]        sh_step;
  logic [1:0]        sh_map;
  logic              sh_adv;
  bit                wr_lo [0:(1 << MEM_ADDR_BITS)-1];
  bit                wr_hi [0:(1 << MEM_ADDR_BITS)-1];
  logic [WORD_W-1:0] bases [$];
  logic [BYTE_W-1:0] hi_pool [4];

  int in_gap_pct;
  int out_stall_pct;
  int hold_asks;
  int hold_taken;
  int hold_left;
  int sent;
  int reads;
  int blocked;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    out_if.ready = 1'b0;
    hold_taken   = 0;
    hold_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_asks != hold_taken) begin
        hold_taken = hold_asks;
        hold_left  = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [MEM_ADDR_BITS-1:0] vram_slot(input logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] r;
    case (sh_map)
      MAP_ROT8:  r = {a[15:8], a[4:0], a[7:5]};
      MAP_ROT9:  r = {a[15:9], a[5:0], a[8:6]};
      MAP_ROT10: r = {a[15:10], a[6:0], a[9:7]};
      default:   r = a;
    endcase
    return r[MEM_ADDR_BITS-1:0];
  endfunction

  function automatic logic readable(input logic [WORD_W-1:0] a);
    return wr_lo[vram_slot(a)] && wr_hi[vram_slot(a)];
  endfunction

  function automatic logic rare_block();
    return $urandom_range(9) == 0;
  endfunction

  task automatic drive_request(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] din,
                               input logic disp);
    @(negedge clk_i);
    while (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_if.valid          <= 1'b0;
      in_if.opcode         <= OPCODE_W'($urandom);
      in_if.data_byte      <= BYTE_W'($urandom);
      in_if.active_display <= 1'($urandom);
      @(negedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.opcode         <= op;
    in_if.data_byte      <= din;
    in_if.active_display <= disp;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Track the request in the shadow, turn any refill from an unwritten word
  // into a blocked one, then hand it to the block.
  task automatic issue(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] din,
                       input logic disp_in);
    logic disp;
    disp = disp_in;
    case (op)
      OP_ADDR_LO, OP_ADDR_HI: begin
        if (op == OP_ADDR_LO) sh_addr[7:0] = din;
        else sh_addr[15:8] = din;
        if (!readable(sh_addr)) disp = 1'b1;
      end
      OP_DATA_LO: begin
        if (!disp) wr_lo[vram_slot(sh_addr)] = 1'b1;
        if (!sh_adv) sh_addr = sh_addr + STRIDE[sh_step];
      end
      OP_DATA_HI: begin
        if (!disp) wr_hi[vram_slot(sh_addr)] = 1'b1;
        if (sh_adv) sh_addr = sh_addr + STRIDE[sh_step];
      end
      OP_READ_LO: begin
        if (!sh_adv) begin
          if (!readable(sh_addr)) disp = 1'b1;
          sh_addr = sh_addr + STRIDE[sh_step];
        end
      end
      OP_READ_HI: begin
        if (sh_adv) begin
          if (!readable(sh_addr)) disp = 1'b1;
          sh_addr = sh_addr + STRIDE[sh_step];
        end
      end
      default: ;
    endcase
    sent++;
    if (op == OP_READ_LO || op == OP_READ_HI) reads++;
    if (disp) blocked++;
    drive_request(op, din, disp);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_STEP_SELECT:     sh_step = val[1:0];
      CFG_ADDRESS_MAPPING: sh_map  = val[1:0];
      CFG_ADVANCE_ON_HIGH: sh_adv  = val[0];
      default: ;
    endcase
  endtask

  // Stop offering requests and wait until every result has come back.
  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_address(input logic [WORD_W-1:0] a);
    issue(OP_ADDR_HI, a[15:8], rare_block());
    issue(OP_ADDR_LO, a[7:0], rare_block());
  endtask

  // The byte that does not advance goes first, so both bytes hit one word.
  task automatic write_burst();
    logic [WORD_W-1:0] base;
    base = {hi_pool[$urandom_range(3)], BYTE_W'($urandom)};
    set_address(base);
    repeat ($urandom_range(1, 8)) begin
      if (sh_adv) begin
        issue(OP_DATA_LO, BYTE_W'($urandom), rare_block());
        issue(OP_DATA_HI, BYTE_W'($urandom), rare_block());
      end else begin
        issue(OP_DATA_HI, BYTE_W'($urandom), rare_block());
        issue(OP_DATA_LO, BYTE_W'($urandom), rare_block());
      end
    end
    bases.push_back(base);
    if (bases.size() > 8) void'(bases.pop_front());
  endtask

  task automatic read_burst();
    set_address(bases[$urandom_range(bases.size() - 1)]);
    repeat ($urandom_range(1, 8)) begin
      if (sh_adv) begin
        issue(OP_READ_LO, BYTE_W'($urandom), rare_block());
        issue(OP_READ_HI, BYTE_W'($urandom), rare_block());
      end else begin
        issue(OP_READ_HI, BYTE_W'($urandom), rare_block());
        issue(OP_READ_LO, BYTE_W'($urandom), rare_block());
      end
    end
  endtask

  initial begin
    logic [4:0]        setting;
    logic [BYTE_W-1:0] junk;
    int                target;
    int                pick;

    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.opcode         = OP_ADDR_LO;
    in_if.data_byte      = '0;
    in_if.active_display = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CFG_STEP_SELECT;
    cfg_if.data          = '0;
    in_gap_pct           = 0;
    out_stall_pct        = 0;
    hold_asks            = 0;
    sent                 = 0;
    reads                = 0;
    blocked              = 0;
    sh_addr              = '0;
    sh_step              = 2'd0;
    sh_map               = MAP_NONE;
    sh_adv               = 1'b0;
    hi_pool              = '{8'h00, 8'hFF, BYTE_W'($urandom), BYTE_W'($urandom)};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // An index past the last register must change nothing.
    write_reg(CFG_UNUSED, 8'hFF);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;

    // Directed requests at the reset settings: step 1, no mapping,
    // advance after the low byte.
    issue(OP_ADDR_LO, 8'h00, 1'b1);
    issue(OP_ADDR_HI, 8'h00, 1'b1);
    issue(OP_DATA_HI, 8'hA5, 1'b0);
    issue(OP_DATA_LO, 8'hFF, 1'b0);
    issue(OP_DATA_HI, 8'h00, 1'b0);
    issue(OP_DATA_LO, 8'h00, 1'b0);
    issue(OP_DATA_HI, 8'hFF, 1'b0);
    issue(OP_DATA_LO, 8'h5A, 1'b0);
    issue(OP_DATA_LO, 8'h77, 1'b1);  // dropped write, address still moves
    issue(OP_ADDR_LO, 8'h00, 1'b0);
    issue(OP_READ_HI, 8'hFF, 1'b0);
    issue(OP_READ_LO, 8'h00, 1'b0);  // returns the byte, then refills
    issue(OP_READ_LO, 8'hFF, 1'b0);
    issue(OP_READ_LO, 8'h00, 1'b1);  // refill blocked by the display
    issue(OP_READ_HI, 8'h00, 1'b0);
    issue(3'd6, 8'hFF, 1'b1);
    issue(3'd7, 8'h00, 1'b0);
    issue(OP_ADDR_HI, 8'hFF, 1'b1);
    issue(OP_ADDR_LO, 8'hFF, 1'b1);
    issue(OP_DATA_HI, 8'h12, 1'b0);
    issue(OP_DATA_LO, 8'h34, 1'b0);  // address wraps to zero
    issue(OP_READ_LO, 8'hFF, 1'b0);
    issue(OP_READ_HI, 8'h00, 1'b0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      case (p)
        0:       setting = {2'd0, MAP_NONE,  1'b0};
        1:       setting = {2'd3, MAP_ROT10, 1'b1};
        2:       setting = {2'd1, MAP_ROT8,  1'b0};
        3:       setting = {2'd2, MAP_ROT9,  1'b1};
        4:       setting = {2'd0, MAP_ROT10, 1'b1};
        5:       setting = {2'd3, MAP_NONE,  1'b0};
        6:       setting = {2'd1, MAP_ROT9,  1'b1};
        default: setting = {2'd2, MAP_ROT8,  1'b0};
      endcase
      junk = BYTE_W'($urandom);
      write_reg(CFG_ADVANCE_ON_HIGH, {junk[7:1], setting[0]});
      write_reg(CFG_STEP_SELECT, {junk[7:2], setting[4:3]});
      write_reg(CFG_ADDRESS_MAPPING, {junk[5:0], setting[2:1]});
      @(negedge clk_i);
      cfg_if.valid <= 1'b0;

      case (p % 4)
        0: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
          hold_asks++;  // receiver holds off long enough to back up the input
        end
        1: begin
          in_gap_pct    = 57;
          out_stall_pct = 0;
        end
        2: begin
          in_gap_pct    = 0;
          out_stall_pct = 57;
        end
        default: begin
          in_gap_pct    = 26;
          out_stall_pct = 26;
        end
      endcase

      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        pick = $urandom_range(99);
        if (pick < 35 || (pick < 75 && bases.size() == 0)) begin
          write_burst();
        end else if (pick < 75) begin
          read_burst();
        end else begin
          repeat ($urandom_range(1, 4))
            issue(OPCODE_W'($urandom), BYTE_W'($urandom), 1'($urandom));
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Ran %0d requests (%0d reads, %0d with the display active) across %0d settings.",
             sent, reads, blocked, PHASE_COUNT);
    $display("Compared %0d result bytes; %0d mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
